/* src/bqf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package bqf_pkg;

	// Default widths of the sample and coefficient words.
	localparam int SAMPLE_W_DEF = 16;
	localparam int COEF_W_DEF   = 24;

	// Output gain is unsigned Q4.12.
	localparam int GAIN_W    = 16;
	localparam int GAIN_BITS = 12;
	localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_BITS;

	// Configuration register indexes.
	localparam int REG_IDX_W = 3;
	typedef enum logic [REG_IDX_W-1:0] {
		REG_B0   = 3'd0,
		REG_B1   = 3'd1,
		REG_B2   = 3'd2,
		REG_C1   = 3'd3,
		REG_C2   = 3'd4,
		REG_GAIN = 3'd5
	} reg_idx_t;

	// Microprogram steps of a sample, one per cycle unless a step waits on its condition.
	localparam int STEP_W = 4;
	typedef enum logic [STEP_W-1:0] {
		ST_ACCEPT = 4'd0,
		ST_MUL_B0 = 4'd1,
		ST_MUL_B1 = 4'd2,
		ST_MUL_B2 = 4'd3,
		ST_MUL_C1 = 4'd4,
		ST_MUL_C2 = 4'd5,
		ST_ACC_LAST = 4'd6,
		ST_ROUND_Y = 4'd7,
		ST_MUL_GAIN = 4'd8,
		ST_OUTPUT = 4'd9
	} step_t;

	// Multiplier operand A: the sample words.
	typedef enum logic [2:0] {
		A_X,
		A_X1,
		A_X2,
		A_Y1,
		A_Y2,
		A_Y
	} a_sel_t;

	// Multiplier operand B: the coefficient words.
	typedef enum logic [2:0] {
		B_B0,
		B_B1,
		B_B2,
		B_C1,
		B_C2,
		B_GAIN
	} b_sel_t;

	// Accumulator operation.
	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_LOAD,
		ACC_ADD
	} acc_op_t;

	// Condition a step waits on before it takes effect.
	typedef enum logic [1:0] {
		W_NONE,
		W_IN,
		W_OUT
	} wait_t;

	// One control word of the microprogram.
	typedef struct packed {
		a_sel_t  a_sel;
		b_sel_t  b_sel;
		logic    mul_en;
		acc_op_t acc_op;
		logic    take_in;
		logic    y_en;
		logic    out_en;
		wait_t   wait_on;
		logic    jump;
		step_t   target;
	} ctrl_t;

	// Status returned from the datapath to the sequencer.
	typedef struct packed {
		logic in_valid;
		logic out_busy;
	} stat_t;

	// Microprogram ROM.
	function automatic ctrl_t ucode(input step_t s);
		ctrl_t cw;
		cw = '{a_sel: A_X, b_sel: B_B0, mul_en: 1'b0, acc_op: ACC_HOLD,
			take_in: 1'b0, y_en: 1'b0, out_en: 1'b0, wait_on: W_NONE,
			jump: 1'b0, target: ST_ACCEPT};
		unique case (s)
			ST_ACCEPT: begin
				cw.take_in = 1'b1;
				cw.wait_on = W_IN;
			end
			ST_MUL_B0: begin
				cw.a_sel  = A_X;
				cw.b_sel  = B_B0;
				cw.mul_en = 1'b1;
			end
			ST_MUL_B1: begin
				cw.a_sel  = A_X1;
				cw.b_sel  = B_B1;
				cw.mul_en = 1'b1;
				cw.acc_op = ACC_LOAD;
			end
			ST_MUL_B2: begin
				cw.a_sel  = A_X2;
				cw.b_sel  = B_B2;
				cw.mul_en = 1'b1;
				cw.acc_op = ACC_ADD;
			end
			ST_MUL_C1: begin
				cw.a_sel  = A_Y1;
				cw.b_sel  = B_C1;
				cw.mul_en = 1'b1;
				cw.acc_op = ACC_ADD;
			end
			ST_MUL_C2: begin
				cw.a_sel  = A_Y2;
				cw.b_sel  = B_C2;
				cw.mul_en = 1'b1;
				cw.acc_op = ACC_ADD;
			end
			ST_ACC_LAST: begin
				cw.acc_op = ACC_ADD;
			end
			ST_ROUND_Y: begin
				cw.y_en = 1'b1;
			end
			ST_MUL_GAIN: begin
				cw.a_sel  = A_Y;
				cw.b_sel  = B_GAIN;
				cw.mul_en = 1'b1;
			end
			ST_OUTPUT: begin
				cw.out_en  = 1'b1;
				cw.wait_on = W_OUT;
				cw.jump    = 1'b1;
				cw.target  = ST_ACCEPT;
			end
			default: begin
				cw.jump   = 1'b1;
				cw.target = ST_ACCEPT;
			end
		endcase
		return cw;
	endfunction

endpackage

`default_nettype wire

/* src/biquad_iir_filter_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// Direct form I biquad filter, one signed sample in and one out.
// Input channel: sample_in with in_valid; the block raises in_stall while a
// sample is being worked on. Output channel: sample_out and clipped with
// out_valid; the receiver holds out_stall high to keep the result waiting.
// Coefficients are written through cfg_valid, cfg_index and cfg_data;
// cfg_ready is always high. Write them only while no sample is in flight.
// One shared multiplier takes the five filter products and the gain
// product in turn, stepped by a ten-entry microprogram; a new sample is
// taken only once the program has brought the last one to its output step.
// A result waits in the output register; the next sample is taken and
// worked on meanwhile, and the program only holds at its last step if that
// register is still full. Reset clears the history to zero, sets b0 and the
// gain to unity and the other coefficients to zero, and empties the output.

module biquad_iir_filter_top import bqf_pkg::*; #(
	parameter int SAMPLE_WIDTH = SAMPLE_W_DEF,
	parameter int COEF_WIDTH   = COEF_W_DEF,
	localparam int CFG_W       = (COEF_WIDTH > GAIN_W) ? COEF_WIDTH : GAIN_W
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic signed [SAMPLE_WIDTH-1:0] sample_in,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic signed [SAMPLE_WIDTH-1:0]      sample_out,
	output logic                                clipped,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [REG_IDX_W-1:0]           cfg_index,
	input  wire logic [CFG_W-1:0]               cfg_data
);

	ctrl_t cw;
	logic  fire;
	stat_t stat;

	// Microprogram control.
	bqf_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cw     (cw),
		.fire   (fire)
	);

	// Registers, multiplier, accumulator and output stage.
	bqf_datapath #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.COEF_WIDTH   (COEF_WIDTH),
		.CFG_W        (CFG_W)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cw         (cw),
		.fire       (fire),
		.in_valid   (in_valid),
		.sample_in  (sample_in),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.out_stall  (out_stall),
		.stat       (stat),
		.out_valid  (out_valid),
		.sample_out (sample_out),
		.clipped    (clipped)
	);

	// Samples are taken only at the accept step of the program.
	assign in_stall  = (cw.wait_on != W_IN);
	assign cfg_ready = 1'b1;

endmodule

`default_nettype wire

/* src/bqf_sequencer.sv */
`timescale 1ns / 1ps
`default_nettype none

module bqf_sequencer import bqf_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire stat_t stat,
	output ctrl_t      cw,
	output logic       fire
);

	step_t step_q;
	step_t step_d;

	// Control word of the current step.
	assign cw = ucode(step_q);

	// A waiting step takes effect only once its condition holds.
	always_comb begin
		unique case (cw.wait_on)
			W_IN:    fire = stat.in_valid;
			W_OUT:   fire = ~stat.out_busy;
			default: fire = 1'b1;
		endcase
	end

	// Next step: hold while waiting, else jump or fall through.
	always_comb begin
		if (!fire) begin
			step_d = step_q;
		end else if (cw.jump) begin
			step_d = cw.target;
		end else begin
			step_d = step_t'(step_q + 1'b1);
		end
	end

	// Step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_ACCEPT;
		end else begin
			step_q <= step_d;
		end
	end

endmodule

`default_nettype wire

/* src/bqf_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module bqf_datapath import bqf_pkg::*; #(
	parameter int SAMPLE_WIDTH = SAMPLE_W_DEF,
	parameter int COEF_WIDTH   = COEF_W_DEF,
	parameter int CFG_W        = (COEF_WIDTH > GAIN_W) ? COEF_WIDTH : GAIN_W
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire ctrl_t                          cw,
	input  wire logic                           fire,
	input  wire logic                           in_valid,
	input  wire logic signed [SAMPLE_WIDTH-1:0] sample_in,
	input  wire logic                           cfg_valid,
	input  wire logic [REG_IDX_W-1:0]           cfg_index,
	input  wire logic [CFG_W-1:0]               cfg_data,
	input  wire logic                           out_stall,
	output stat_t                               stat,
	output logic                                out_valid,
	output logic signed [SAMPLE_WIDTH-1:0]      sample_out,
	output logic                                clipped
);

	localparam int SW    = SAMPLE_WIDTH;
	localparam int CW    = COEF_WIDTH;
	localparam int FRAC  = CW - 4;
	localparam int BW    = CFG_W + 1;
	localparam int PW    = SW + BW;
	localparam int ACC_W = (SW + CW + 3 > 64) ? 64 : SW + CW + 3;

	localparam logic [CW-1:0]    B0_ONE    = {3'b000, 1'b1, {FRAC{1'b0}}};
	localparam logic [FRAC-1:0]  ACC_HALF  = {1'b1, {(FRAC-1){1'b0}}};
	localparam logic [GAIN_BITS-1:0] GAIN_HALF = {1'b1, {(GAIN_BITS-1){1'b0}}};
	localparam logic [SW-1:0]    S_MAX     = {1'b0, {(SW-1){1'b1}}};
	localparam logic [SW-1:0]    S_MIN     = {1'b1, {(SW-1){1'b0}}};

	// Coefficient registers.
	logic signed [CW-1:0]     b0_q, b1_q, b2_q, c1_q, c2_q;
	logic        [GAIN_W-1:0] gain_q;

	// Sample history and working registers.
	logic signed [SW-1:0]    x_q, x1_q, x2_q, y1_q, y2_q, y_q;
	logic signed [PW-1:0]    prod_q;
	logic signed [ACC_W-1:0] acc_q;
	logic                    clip_q;
	logic                    out_valid_q;
	logic signed [SW-1:0]    sample_out_q;
	logic                    clipped_q;

	logic signed [SW-1:0]    a_op;
	logic signed [BW-1:0]    b_op;
	logic signed [PW-1:0]    prod_w;
	logic signed [ACC_W-1:0] prod_ext;
	logic signed [ACC_W-1:0] acc_rnd;
	logic signed [ACC_W-1:0] acc_sh;
	logic                    y_ovf;
	logic signed [SW-1:0]    y_sat;
	logic signed [PW-1:0]    g_rnd;
	logic signed [PW-1:0]    g_sh;
	logic                    g_ovf;
	logic signed [SW-1:0]    g_sat;
	logic                    out_busy;

	// Configuration writes; indexes past the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b0_q   <= B0_ONE;
			b1_q   <= '0;
			b2_q   <= '0;
			c1_q   <= '0;
			c2_q   <= '0;
			gain_q <= GAIN_ONE;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_B0:   b0_q   <= cfg_data[CW-1:0];
				REG_B1:   b1_q   <= cfg_data[CW-1:0];
				REG_B2:   b2_q   <= cfg_data[CW-1:0];
				REG_C1:   c1_q   <= cfg_data[CW-1:0];
				REG_C2:   c2_q   <= cfg_data[CW-1:0];
				REG_GAIN: gain_q <= cfg_data[GAIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Operand A selection.
	always_comb begin
		unique case (cw.a_sel)
			A_X:     a_op = x_q;
			A_X1:    a_op = x1_q;
			A_X2:    a_op = x2_q;
			A_Y1:    a_op = y1_q;
			A_Y2:    a_op = y2_q;
			A_Y:     a_op = y_q;
			default: a_op = '0;
		endcase
	end

	// Operand B selection; the gain is unsigned and zero-extended.
	always_comb begin
		unique case (cw.b_sel)
			B_B0:    b_op = BW'(b0_q);
			B_B1:    b_op = BW'(b1_q);
			B_B2:    b_op = BW'(b2_q);
			B_C1:    b_op = BW'(c1_q);
			B_C2:    b_op = BW'(c2_q);
			B_GAIN:  b_op = signed'({{(BW-GAIN_W){1'b0}}, gain_q});
			default: b_op = '0;
		endcase
	end

	// The shared multiplier.
	assign prod_w   = a_op * b_op;
	assign prod_ext = ACC_W'(prod_q);

	// Round the sum half up, drop the fraction, saturate to a sample.
	assign acc_rnd = acc_q + ACC_W'(ACC_HALF);
	assign acc_sh  = acc_rnd >>> FRAC;
	assign y_ovf   = !((&acc_sh[ACC_W-1:SW-1]) || (~|acc_sh[ACC_W-1:SW-1]));
	assign y_sat   = y_ovf ? (acc_sh[ACC_W-1] ? S_MIN : S_MAX) : acc_sh[SW-1:0];

	// Same for the gain product, which has GAIN_BITS fraction bits.
	assign g_rnd = prod_q + PW'(GAIN_HALF);
	assign g_sh  = g_rnd >>> GAIN_BITS;
	assign g_ovf = !((&g_sh[PW-1:SW-1]) || (~|g_sh[PW-1:SW-1]));
	assign g_sat = g_ovf ? (g_sh[PW-1] ? S_MIN : S_MAX) : g_sh[SW-1:0];

	// Working registers that need no reset.
	always_ff @(posedge clk) begin
		if (fire && cw.take_in) begin
			x_q <= sample_in;
		end
		if (fire && cw.mul_en) begin
			prod_q <= prod_w;
		end
		if (fire) begin
			case (cw.acc_op)
				ACC_LOAD: acc_q <= prod_ext;
				ACC_ADD:  acc_q <= acc_q + prod_ext;
				default: begin
				end
			endcase
		end
		if (fire && cw.y_en) begin
			y_q    <= y_sat;
			clip_q <= y_ovf;
		end
		if (fire && cw.out_en) begin
			sample_out_q <= g_sat;
			clipped_q    <= clip_q | g_ovf;
		end
	end

	// Filter history, cleared at reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x1_q <= '0;
			x2_q <= '0;
			y1_q <= '0;
			y2_q <= '0;
		end else if (fire && cw.y_en) begin
			x2_q <= x1_q;
			x1_q <= x_q;
			y2_q <= y1_q;
			y1_q <= y_sat;
		end
	end

	// Output register: full until the transaction completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && cw.out_en) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_busy      = out_valid_q & out_stall;
	assign stat.in_valid = in_valid;
	assign stat.out_busy = out_busy;
	assign out_valid     = out_valid_q;
	assign sample_out    = sample_out_q;
	assign clipped       = clipped_q;

endmodule

`default_nettype wire

/* src/bqf_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module bqf_checker import bqf_pkg::*; #(
	parameter int SAMPLE_WIDTH = SAMPLE_W_DEF,
	parameter int COEF_WIDTH   = COEF_W_DEF
) (
	input wire logic                    clk,
	input wire logic                    arst_n,
	input wire logic                    in_valid,
	input wire logic                    in_stall,
	input wire logic                    out_valid,
	input wire logic                    out_stall,
	input wire logic [SAMPLE_WIDTH-1:0] sample_out,
	input wire logic                    clipped
);

	// A stalled result holds until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=>
		(out_valid && $stable(sample_out) && $stable(clipped)))
		else $error("stalled result changed or dropped");

	// After an input transaction the block is busy in the next cycle.
	a_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken in back-to-back cycles");

	// At one point after an input transaction, no new result may appear yet.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |-> ##8 !$rose(out_valid))
		else $error("result appeared too early");

	// A result is loaded only from the last step, never while accepting.
	a_load_step: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result loaded at the accept step");

endmodule

bind biquad_iir_filter_top bqf_checker #(
	.SAMPLE_WIDTH (SAMPLE_WIDTH),
	.COEF_WIDTH   (COEF_WIDTH)
) u_bqf_checker (.*);

`default_nettype wire
